/* rtl/pme_pkg.sv */
package pme_pkg;

  localparam int unsigned MaxGenesDef = 64;
  localparam int unsigned GeneWidthDef = 16;

  localparam int unsigned PosW = 6;
  localparam int unsigned LenW = 7;
  localparam int unsigned ValW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_GENOME_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BEGIN_SKIP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_SKIP = 2'd2;

  localparam logic [LenW-1:0] GenomeLengthRst = 7'd64;

  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_READ     = 3'd1,
    ACT_REVERSE  = 3'd2,
    ACT_MIGRATE  = 3'd3,
    ACT_NEIGHBOUR = 3'd4,
    ACT_SWAP_TWO = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    K_LOAD,
    K_READ,
    K_REV,
    K_PAIR
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            swap_en;
    logic [LenW-1:0] lo;
    logic [LenW-1:0] hi;
    logic            par_en;
    logic            par;
    logic            wr;
    logic [PosW-1:0] addr;
    logic            tap_cap;
    logic            tap_shift;
  } ctl_t;

endpackage

/* rtl/pme_cell.sv */
module pme_cell
  import pme_pkg::*;
#(
  parameter int unsigned GW  = GeneWidthDef,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  ctl_t          ctl_i,
  input  logic [GW-1:0] wdata_i,
  input  logic [GW-1:0] left_gene_i,
  input  logic [GW-1:0] right_gene_i,
  input  logic          left_sw_i,
  input  logic [GW-1:0] tap_in_i,
  output logic          sw_o,
  output logic [GW-1:0] gene_o,
  output logic [GW-1:0] tap_o
);

  logic [GW-1:0] gene_q, gene_d;
  logic [GW-1:0] tap_q, tap_d;
  logic          hit;
  logic          par_ok;

  assign hit    = (IDX == int'(ctl_i.addr));
  assign par_ok = !ctl_i.par_en || ((IDX % 2) == int'(ctl_i.par));
  assign sw_o   = ctl_i.swap_en && (IDX >= int'(ctl_i.lo)) && (IDX < int'(ctl_i.hi)) && par_ok;

  always_comb begin
    gene_d = gene_q;
    if (ctl_i.wr && hit) begin
      gene_d = wdata_i;
    end else if (sw_o) begin
      gene_d = right_gene_i;
    end else if (left_sw_i) begin
      gene_d = left_gene_i;
    end
  end

  always_comb begin
    tap_d = tap_q;
    if (ctl_i.tap_cap && hit) begin
      tap_d = gene_q;
    end else if (ctl_i.tap_shift) begin
      tap_d = tap_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    gene_q <= gene_d;
    tap_q  <= tap_d;
  end

  assign gene_o = gene_q;
  assign tap_o  = tap_q;

endmodule

/* rtl/pme_seq.sv */
module pme_seq
  import pme_pkg::*;
#(
  parameter int unsigned MAX_GENES  = MaxGenesDef,
  parameter int unsigned GENE_WIDTH = GeneWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            action_i,
  input  logic [PosW-1:0]       pos_a_i,
  input  logic [PosW-1:0]       pos_b_i,
  input  logic                  backward_i,
  input  logic [PosW-1:0]       steps_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ValW-1:0]       read_value_o,
  output logic                  status_o,
  input  logic [GENE_WIDTH-1:0] tap_i,
  output ctl_t                  ctl_o
);

  state_e state_q, state_d;

  logic [LenW-1:0] len_q;
  logic [PosW-1:0] bskip_q;
  logic [PosW-1:0] eskip_q;

  kind_e           kind_q, kind_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [LenW-1:0] ph2_q, ph2_d;
  logic [LenW-1:0] p_q, p_d;
  logic            dec_q, dec_d;
  logic [LenW-1:0] seg_lo_q, seg_lo_d;
  logic [LenW-1:0] seg_hi_q, seg_hi_d;
  logic            par_q, par_d;
  logic            first_q, first_d;
  logic [PosW-1:0] addr_q, addr_d;
  logic            err_q, err_d;

  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] rd_q, rd_d;
  logic            st_q, st_d;

  logic            accept;
  logic            deliver;
  logic            last;

  logic              len_ok;
  logic signed [8:0] len_s, lo_s, hi_s, a_s, b_s, st_s;
  logic              win, a_in, b_in;
  logic [LenW-1:0]   a7, b7, x7, y7, ry7, gap;
  logic              pl_ok;
  kind_e             pl_kind;
  logic [LenW-1:0]   pl_cnt, pl_ph2, pl_p, pl_lo, pl_hi;
  logic              pl_dec;

  assign accept  = in_valid_i && in_ready_o;
  assign deliver = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign last    = (cnt_q == LenW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= GenomeLengthRst;
      bskip_q <= '0;
      eskip_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GENOME_LENGTH: len_q   <= cfg_data_i;
        CFG_BEGIN_SKIP:    bskip_q <= cfg_data_i[PosW-1:0];
        CFG_END_SKIP:      eskip_q <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_ok = (len_q >= LenW'(2)) && (int'(len_q) <= MAX_GENES);
    len_s  = $signed({2'b00, len_q});
    lo_s   = $signed({3'b000, bskip_q});
    hi_s   = len_s - 9'sd1 - $signed({3'b000, eskip_q});
    a_s    = $signed({3'b000, pos_a_i});
    b_s    = $signed({3'b000, pos_b_i});
    st_s   = $signed({3'b000, steps_i});
    win    = lo_s <= hi_s;
    a_in   = win && (a_s >= lo_s) && (a_s <= hi_s);
    b_in   = win && (b_s >= lo_s) && (b_s <= hi_s);
    a7     = {1'b0, pos_a_i};
    b7     = {1'b0, pos_b_i};
    ry7    = ((a7 + LenW'(1)) == len_q) ? '0 : (a7 + LenW'(1));
    x7     = a7;
    y7     = b7;
    gap    = '0;
    pl_ok   = 1'b0;
    pl_kind = K_PAIR;
    pl_cnt  = '0;
    pl_ph2  = '0;
    pl_p    = a7;
    pl_dec  = 1'b0;
    pl_lo   = '0;
    pl_hi   = '0;
    case (action_e'(action_i))
      ACT_LOAD: begin
        pl_ok   = a7 < len_q;
        pl_kind = K_LOAD;
        pl_cnt  = LenW'(1);
      end
      ACT_READ: begin
        pl_ok   = a7 < len_q;
        pl_kind = K_READ;
        pl_cnt  = a7 + LenW'(1);
      end
      ACT_REVERSE: begin
        pl_ok   = a_in && b_in;
        pl_kind = K_REV;
        if (a7 == b7) begin
          y7 = ry7;
        end
        if (y7 < a7) begin
          x7 = y7;
          y7 = a7;
        end
        pl_lo  = x7;
        pl_hi  = y7;
        pl_cnt = y7 - x7 + LenW'(1);
      end
      ACT_MIGRATE: begin
        pl_cnt = {1'b0, steps_i};
        if (!backward_i) begin
          pl_ok = win && (a_s >= lo_s) && (a_s <= hi_s - 9'sd1) && (st_s >= 9'sd1)
                  && (st_s <= hi_s - a_s);
          pl_p  = a7;
        end else begin
          pl_ok  = win && (a_s >= lo_s + 9'sd1) && (a_s <= hi_s) && (st_s >= 9'sd1)
                   && (st_s <= a_s - lo_s);
          pl_p   = a7 - LenW'(1);
          pl_dec = 1'b1;
        end
      end
      ACT_NEIGHBOUR: begin
        pl_ok = a_in;
        if (a_s < hi_s) begin
          pl_cnt = LenW'(1);
        end else begin
          x7     = {1'b0, bskip_q};
          y7     = a7;
          gap    = y7 - x7;
          pl_p   = x7;
          pl_cnt = gap;
          pl_ph2 = (gap == '0) ? '0 : gap - LenW'(1);
        end
      end
      ACT_SWAP_TWO: begin
        pl_ok = a_in && b_in;
        if (b7 < a7) begin
          x7 = b7;
          y7 = a7;
        end
        gap    = y7 - x7;
        pl_p   = x7;
        pl_cnt = gap;
        pl_ph2 = (gap == '0) ? '0 : gap - LenW'(1);
      end
      default: pl_ok = 1'b0;
    endcase
    pl_ok = pl_ok && len_ok;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (pl_ok && (pl_cnt != '0)) ? S_RUN : S_DONE;
        end
      end
      S_RUN: begin
        if (last && (ph2_q == '0)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (deliver) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    ph2_d       = ph2_q;
    p_d         = p_q;
    dec_d       = dec_q;
    seg_lo_d    = seg_lo_q;
    seg_hi_d    = seg_hi_q;
    par_d       = par_q;
    first_d     = first_q;
    addr_d      = addr_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_d        = rd_q;
    st_d        = st_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = pl_kind;
          cnt_d    = pl_cnt;
          ph2_d    = pl_ph2;
          p_d      = pl_p;
          dec_d    = pl_dec;
          seg_lo_d = pl_lo;
          seg_hi_d = pl_hi;
          par_d    = pl_lo[0];
          first_d  = 1'b1;
          addr_d   = pos_a_i;
          err_d    = !pl_ok;
        end
      end
      S_RUN: begin
        first_d = 1'b0;
        cnt_d   = cnt_q - LenW'(1);
        par_d   = !par_q;
        p_d     = dec_q ? (p_q - LenW'(1)) : (p_q + LenW'(1));
        if (last && (ph2_q != '0)) begin
          cnt_d = ph2_q;
          ph2_d = '0;
          dec_d = 1'b1;
          p_d   = p_q - LenW'(1);
        end
      end
      S_DONE: begin
        if (deliver) begin
          out_valid_d = 1'b1;
          rd_d        = ((kind_q == K_READ) && !err_q) ? ValW'(tap_i) : '0;
          st_d        = err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      kind_q      <= K_PAIR;
      cnt_q       <= '0;
      ph2_q       <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      ph2_q       <= ph2_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    dec_q    <= dec_d;
    seg_lo_q <= seg_lo_d;
    seg_hi_q <= seg_hi_d;
    par_q    <= par_d;
    addr_q   <= addr_d;
    err_q    <= err_d;
    rd_q     <= rd_d;
    st_q     <= st_d;
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.addr      = addr_q;
    ctl_o.par       = par_q;
    ctl_o.par_en    = (kind_q == K_REV);
    ctl_o.lo        = (kind_q == K_REV) ? seg_lo_q : p_q;
    ctl_o.hi        = (kind_q == K_REV) ? seg_hi_q : (p_q + LenW'(1));
    if (state_q == S_RUN) begin
      ctl_o.swap_en   = (kind_q == K_REV) || (kind_q == K_PAIR);
      ctl_o.wr        = (kind_q == K_LOAD);
      ctl_o.tap_shift = (kind_q == K_READ);
      ctl_o.tap_cap   = (kind_q == K_READ) && first_q;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_q;
  assign status_o     = st_q;

endmodule

/* rtl/permutation_mutation_engine_core.sv */
// Permutation mutation engine. The genome lives in a row of cells, one element per cell, and
// every mutation is carried out as adjacent swaps between neighbouring cells, one swap per cell
// pair per cycle. An item is first taken in, then: load writes the element into its cell; read
// captures the element at pos_a, which travels down the read chain to cell 0; reverse works by
// alternating rounds of parallel neighbour swaps; migrate makes one swap per step; swap two
// positions carries the first element up to the second and the displaced one back down (the
// wrap case of neighbour swap is the same); a plain neighbour swap is a single swap; then the
// result is placed in the output register. Errors and no-op swaps skip the working phase. One
// item is worked on at a time, but a new request is taken while the previous result still
// waits on the output. Configuration writes are always ready and must only be made while the
// block is idle. Elements never loaded read back as unknown values.
module permutation_mutation_engine_core
  import pme_pkg::*;
#(
  parameter int unsigned MAX_GENES  = MaxGenesDef,
  parameter int unsigned GENE_WIDTH = GeneWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_a [5:0], pos_b [11:6], backward [12], steps [18:13], load_value [34:19], zero [39:35]
  input  logic [39:0]         s_axis_tdata,
  // action [2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_value [15:0]
  output logic [15:0]         m_axis_tdata,
  // status [0]
  output logic                m_axis_tuser
);

  ctl_t                  ctl;
  logic [GENE_WIDTH-1:0] wdata;
  logic [GENE_WIDTH-1:0] gene [MAX_GENES];
  logic [GENE_WIDTH-1:0] tap [MAX_GENES];
  logic                  sw [MAX_GENES];
  logic [GENE_WIDTH-1:0] ld_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ld_q <= GENE_WIDTH'(s_axis_tdata[34:19]);
    end
  end

  assign wdata = ld_q;

  pme_seq #(
    .MAX_GENES (MAX_GENES),
    .GENE_WIDTH(GENE_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .pos_a_i     (s_axis_tdata[5:0]),
    .pos_b_i     (s_axis_tdata[11:6]),
    .backward_i  (s_axis_tdata[12]),
    .steps_i     (s_axis_tdata[18:13]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .read_value_o(m_axis_tdata),
    .status_o    (m_axis_tuser),
    .tap_i       (tap[0]),
    .ctl_o       (ctl)
  );

  for (genvar j = 0; j < MAX_GENES; j++) begin : g_cell
    logic [GENE_WIDTH-1:0] lg;
    logic [GENE_WIDTH-1:0] rg;
    logic [GENE_WIDTH-1:0] rt;
    logic                  lsw;

    if (j == 0) begin : g_first
      assign lg  = '0;
      assign lsw = 1'b0;
    end else begin : g_mid_l
      assign lg  = gene[j-1];
      assign lsw = sw[j-1];
    end

    if (j == MAX_GENES - 1) begin : g_last
      assign rg = '0;
      assign rt = '0;
    end else begin : g_mid_r
      assign rg = gene[j+1];
      assign rt = tap[j+1];
    end

    pme_cell #(
      .GW (GENE_WIDTH),
      .IDX(j)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .wdata_i     (wdata),
      .left_gene_i (lg),
      .right_gene_i(rg),
      .left_sw_i   (lsw),
      .tap_in_i    (rt),
      .sw_o        (sw[j]),
      .gene_o      (gene[j]),
      .tap_o       (tap[j])
    );
  end

endmodule

/* rtl/pme_checker.sv */
module pme_checker
  import pme_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [39:0]         s_axis_tdata,
  input logic [2:0]          s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [15:0]         m_axis_tdata,
  input logic                m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("failed request returned a non-zero value");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new request taken while one is in progress");

endmodule

bind permutation_mutation_engine_core pme_checker u_pme_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .cfg_index_i  (cfg_index_i),
  .cfg_data_i   (cfg_data_i),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
